// ----- sv/tdr_pkg.sv -----
// Package for the triangle depth rasterizer.
// Holds the item structs, command and register codes, state enums and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdr_pkg;

  // Fixed field widths of the channels.
  localparam int CRD_W  = 12;  // signed screen coordinate
  localparam int ZIN_W  = 24;  // inverse depth on the ports
  localparam int SCR_W  = 10;  // screen size register
  localparam int CNT_W  = 19;  // written pixel count
  localparam int CFG_AW = 1;   // register index

  // Internal arithmetic widths.
  localparam int DIF_W = 14;   // coordinate differences and pixel positions
  localparam int DOT_W = 28;   // Gram dot products
  localparam int WT_W  = 56;   // products, denominator and signed weights
  localparam int WU_W  = 52;   // non-negative weights and denominator

  localparam logic [SCR_W-1:0] SCR_RESET = 10'd420;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_CLEAR = 2'd0;
  localparam func_t FUNC_TRI   = 2'd1;
  localparam func_t FUNC_READ  = 2'd2;

  typedef logic [CFG_AW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SCREEN_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_SCREEN_HEIGHT = 1'd1;

  typedef struct packed {
    func_t                   func;
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic [ZIN_W-1:0]        az;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by_row;
    logic [ZIN_W-1:0]        bz;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [ZIN_W-1:0]        cz;
  } tdr_in_t;

  typedef struct packed {
    logic [ZIN_W-1:0] depth_out;
    logic [CNT_W-1:0] pixels_written;
    logic             out_of_screen;
  } tdr_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_TRI_EDGE,
    ST_TRI_DOT,
    ST_TRI_DENP,
    ST_TRI_DEN,
    ST_PIX_DOT,
    ST_PIX_PROD,
    ST_PIX_WT,
    ST_PIX_TEST,
    ST_PIX_INTERP,
    ST_FINISH
  } tdr_state_t;

  typedef enum logic [1:0] {
    IP_IDLE,
    IP_MUL,
    IP_DIV
  } tdr_ip_state_t;

  // Sign-extends a screen coordinate to the difference width.
  function automatic logic signed [DIF_W-1:0] sx(logic [CRD_W-1:0] v);
    return {{(DIF_W-CRD_W){v[CRD_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- sv/tdr_depth_mem.sv -----
// Depth store of the rasterizer: one write port, one read port.
// Read data is registered and holds until the next read. Uses nothing else.
`timescale 1ns / 1ps
`default_nettype none

module tdr_depth_mem #(
  parameter int DW    = 24,
  parameter int AW    = 18,
  parameter int DEPTH = 262144
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tdr_interp.sv -----
// Depth interpolation unit: floor((z0*u + z1*v + z2*w) / den).
// Shift-add multiply then restoring division, one bit a cycle. Uses tdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdr_interp #(
  parameter int ZW = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ZW-1:0]             z0,
  input  wire logic [ZW-1:0]             z1,
  input  wire logic [ZW-1:0]             z2,
  input  wire logic [tdr_pkg::WU_W-1:0]  u,
  input  wire logic [tdr_pkg::WU_W-1:0]  v,
  input  wire logic [tdr_pkg::WU_W-1:0]  w,
  input  wire logic [tdr_pkg::WU_W-1:0]  den,
  output logic                           done,
  output logic [ZW-1:0]                  q
);

  import tdr_pkg::*;

  localparam int NW = ZW + WU_W;
  localparam int CW = $clog2(ZW);
  localparam logic [CW-1:0] CNT_TOP = CW'(ZW - 1);

  tdr_ip_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic          done_r, done_nxt;

  logic [NW-1:0]   mul_sum;
  logic [WU_W:0]   div_t;
  logic [WU_W:0]   div_d;
  logic            div_ge;
  logic [WU_W-1:0] div_rem;

  // One multiply step: the weights picked by the current bit of each depth.
  always_comb begin
    mul_sum = {acc_r[NW-2:0], 1'b0}
            + (z0[cnt_r] ? NW'(u) : '0)
            + (z1[cnt_r] ? NW'(v) : '0)
            + (z2[cnt_r] ? NW'(w) : '0);
  end

  // One division step on the upper part; quotient bits enter at the bottom.
  always_comb begin
    div_t   = {acc_r[NW-1:ZW], acc_r[ZW-1]};
    div_d   = div_t - {1'b0, den};
    div_ge  = (div_t >= {1'b0, den});
    div_rem = div_ge ? div_d[WU_W-1:0] : div_t[WU_W-1:0];
  end

  // Sequencer.
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    case (st_r)
      IP_IDLE: begin
        if (start) begin
          st_nxt  = IP_MUL;
          cnt_nxt = CNT_TOP;
          acc_nxt = '0;
        end
      end
      IP_MUL: begin
        acc_nxt = mul_sum;
        if (cnt_r == '0) begin
          st_nxt  = IP_DIV;
          cnt_nxt = CNT_TOP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      IP_DIV: begin
        acc_nxt = {div_rem, acc_r[ZW-2:0], div_ge};
        if (cnt_r == '0) begin
          st_nxt   = IP_IDLE;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        st_nxt = IP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= IP_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign q    = acc_r[ZW-1:0];

endmodule

`default_nettype wire

// ----- sv/triangle_depth_rasterizer.sv -----
// Top level of the triangle rasterizer with an inverse-depth store.
// Uses tdr_pkg, tdr_depth_mem and tdr_interp.
//
//   channel  ports                        direction  accepted when
//   in       in_valid, in_stall, in_data   input      in_valid && !in_stall
//   out      out_valid, out_stall, out_data output    out_valid && !out_stall
//   cfg      cfg_we, cfg_addr, cfg_wdata   input      cfg_we
//
// Clear and the pass after reset sweep the store at one entry a cycle, with
// no item taken meanwhile. A read goes through a wait state; a triangle goes
// through edge, dot and denominator setup, then walks its clipped box pixel
// by pixel and runs the bit-serial interpolation unit on each covered pixel.
// A finished result waits in the output register while the next item enters.
`timescale 1ns / 1ps
`default_nettype none

module triangle_depth_rasterizer #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int DEPTH_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire tdr_pkg::tdr_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output tdr_pkg::tdr_out_t                 out_data,
  input  wire logic                         cfg_we,
  input  wire logic [tdr_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [tdr_pkg::SCR_W-1:0]    cfg_wdata
);

  import tdr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XI    = $clog2(MAX_WIDTH);
  localparam int YI    = $clog2(MAX_HEIGHT);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic signed [DIF_W-1:0] MAXW_S = DIF_W'(MAX_WIDTH);
  localparam logic signed [DIF_W-1:0] MAXH_S = DIF_W'(MAX_HEIGHT);
  localparam logic signed [DIF_W-1:0] ONE_S  = DIF_W'(1);
  localparam logic signed [DIF_W-1:0] ZERO_S = '0;

  tdr_state_t state_r, state_nxt;

  // Control registers.
  logic [SCR_W-1:0] scr_w_r, scr_h_r;
  logic [AW-1:0]    clr_r;
  logic             clr_cmd_r;
  logic             out_valid_r;
  tdr_out_t         out_r;

  // Item and datapath registers.
  tdr_in_t                 in_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ZIN_W-1:0]        rdepth_r;
  logic                    roos_r;
  logic signed [DIF_W-1:0] e0x_r, e0y_r, e1x_r, e1y_r;
  logic signed [DIF_W-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [DIF_W-1:0] col_r, row_r;
  logic signed [DOT_W-1:0] d00_r, d01_r, d11_r, d20_r, d21_r;
  logic signed [WT_W-1:0]  prod_r [4];
  logic signed [WT_W-1:0]  den_r, u_r, v_r, w_r;

  // Memory and interpolation connections.
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DEPTH_BITS-1:0] mem_wdata, mem_rdata;
  logic                  ip_start, ip_done;
  logic [DEPTH_BITS-1:0] ip_q;

  // Combinational helpers.
  logic signed [DIF_W-1:0] aw_s, ah_s;
  logic signed [DIF_W-1:0] rx, ry;
  logic                    rd_in;
  logic [AW-1:0]           rd_addr, pix_addr;
  logic signed [DIF_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [DIF_W-1:0] bminx, bmaxx, bminy, bmaxy;
  logic signed [DIF_W-1:0] e2x, e2y;
  logic signed [WT_W-1:0]  den_nxt;
  logic                    covered, col_last, row_last;
  logic                    advance, out_load, accept;

  // Active screen size, saturated to the store size.
  always_comb begin
    aw_s = $signed({{(DIF_W-SCR_W){1'b0}}, scr_w_r});
    ah_s = $signed({{(DIF_W-SCR_W){1'b0}}, scr_h_r});
    if (aw_s > MAXW_S) begin
      aw_s = MAXW_S;
    end
    if (ah_s > MAXH_S) begin
      ah_s = MAXH_S;
    end
  end

  // Read command address and screen test.
  always_comb begin
    rx      = sx(in_data.ax);
    ry      = sx(in_data.ay);
    rd_in   = !rx[DIF_W-1] && !ry[DIF_W-1] && (rx < aw_s) && (ry < ah_s);
    rd_addr = AW'(ry[YI-1:0]) * AW'(MAX_WIDTH) + AW'(rx[XI-1:0]);
  end

  // Vertices of the held item and their clipped bounding box.
  always_comb begin
    x0 = sx(in_r.ax);
    y0 = sx(in_r.ay);
    x1 = sx(in_r.bx);
    y1 = sx(in_r.by_row);
    x2 = sx(in_r.cx);
    y2 = sx(in_r.cy);
    bminx = x0;
    bmaxx = x0;
    bminy = y0;
    bmaxy = y0;
    if (x1 < bminx) bminx = x1;
    if (x2 < bminx) bminx = x2;
    if (x1 > bmaxx) bmaxx = x1;
    if (x2 > bmaxx) bmaxx = x2;
    if (y1 < bminy) bminy = y1;
    if (y2 < bminy) bminy = y2;
    if (y1 > bmaxy) bmaxy = y1;
    if (y2 > bmaxy) bmaxy = y2;
    if (bminx < ZERO_S) bminx = ZERO_S;
    if (bminy < ZERO_S) bminy = ZERO_S;
    if (bmaxx > aw_s) bmaxx = aw_s;
    if (bmaxy > ah_s) bmaxy = ah_s;
  end

  // Pixel walk helpers.
  always_comb begin
    e2x      = col_r - x0;
    e2y      = row_r - y0;
    pix_addr = AW'(row_r[YI-1:0]) * AW'(MAX_WIDTH) + AW'(col_r[XI-1:0]);
    den_nxt  = prod_r[0] - prod_r[1];
    covered  = !u_r[WT_W-1] && !v_r[WT_W-1] && !w_r[WT_W-1];
    col_last = (col_r + ONE_S) >= maxx_r;
    row_last = (row_r + ONE_S) >= maxy_r;
  end

  // Next state and control.
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = ip_q;
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    ip_start  = 1'b0;
    advance   = 1'b0;
    out_load  = 1'b0;
    accept    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == CLR_LAST) begin
          state_nxt = clr_cmd_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          accept = 1'b1;
          case (in_data.func)
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            FUNC_TRI:   state_nxt = ST_TRI_EDGE;
            FUNC_READ: begin
              if (rd_in) begin
                mem_re    = 1'b1;
                mem_raddr = rd_addr;
                state_nxt = ST_RD_WAIT;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_RD_WAIT:  state_nxt = ST_FINISH;
      ST_TRI_EDGE: state_nxt = ST_TRI_DOT;
      ST_TRI_DOT:  state_nxt = ST_TRI_DENP;
      ST_TRI_DENP: state_nxt = ST_TRI_DEN;
      ST_TRI_DEN: begin
        if ((den_nxt > 0) && (minx_r < maxx_r) && (miny_r < maxy_r)) begin
          state_nxt = ST_PIX_DOT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PIX_DOT: begin
        mem_re    = 1'b1;
        state_nxt = ST_PIX_PROD;
      end
      ST_PIX_PROD: state_nxt = ST_PIX_WT;
      ST_PIX_WT:   state_nxt = ST_PIX_TEST;
      ST_PIX_TEST: begin
        if (covered) begin
          ip_start  = 1'b1;
          state_nxt = ST_PIX_INTERP;
        end else begin
          advance = 1'b1;
        end
      end
      ST_PIX_INTERP: begin
        if (ip_done) begin
          mem_we  = (ip_q > mem_rdata);
          advance = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (advance) begin
      state_nxt = (col_last && row_last) ? ST_FINISH : ST_PIX_DOT;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
      scr_w_r     <= SCR_RESET;
      scr_h_r     <= SCR_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= (clr_r == CLR_LAST) ? '0 : clr_r + 1'b1;
      end
      if (accept) begin
        clr_cmd_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r     <= in_data;
      cnt_r    <= '0;
      rdepth_r <= '0;
      roos_r   <= (in_data.func == FUNC_READ) && !rd_in;
    end
    if (out_load) begin
      out_r <= '{depth_out: rdepth_r, pixels_written: cnt_r, out_of_screen: roos_r};
    end
    case (state_r)
      ST_RD_WAIT: rdepth_r <= ZIN_W'(mem_rdata);
      ST_TRI_EDGE: begin
        e0x_r  <= x1 - x0;
        e0y_r  <= y1 - y0;
        e1x_r  <= x2 - x0;
        e1y_r  <= y2 - y0;
        minx_r <= bminx;
        maxx_r <= bmaxx;
        miny_r <= bminy;
        maxy_r <= bmaxy;
      end
      ST_TRI_DOT: begin
        d00_r <= e0x_r * e0x_r + e0y_r * e0y_r;
        d01_r <= e0x_r * e1x_r + e0y_r * e1y_r;
        d11_r <= e1x_r * e1x_r + e1y_r * e1y_r;
      end
      ST_TRI_DENP: begin
        prod_r[0] <= d00_r * d11_r;
        prod_r[1] <= d01_r * d01_r;
      end
      ST_TRI_DEN: begin
        den_r <= den_nxt;
        col_r <= minx_r;
        row_r <= miny_r;
      end
      ST_PIX_DOT: begin
        d20_r <= e2x * e0x_r + e2y * e0y_r;
        d21_r <= e2x * e1x_r + e2y * e1y_r;
      end
      ST_PIX_PROD: begin
        prod_r[0] <= d11_r * d20_r;
        prod_r[1] <= d01_r * d21_r;
        prod_r[2] <= d00_r * d21_r;
        prod_r[3] <= d01_r * d20_r;
      end
      ST_PIX_WT: begin
        v_r <= prod_r[0] - prod_r[1];
        w_r <= prod_r[2] - prod_r[3];
        u_r <= den_r - (prod_r[0] - prod_r[1]) - (prod_r[2] - prod_r[3]);
      end
      default: ;
    endcase
    if (mem_we && (state_r == ST_PIX_INTERP)) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (advance) begin
      if (col_last) begin
        col_r <= minx_r;
        row_r <= row_r + ONE_S;
      end else begin
        col_r <= col_r + ONE_S;
      end
    end
  end

  tdr_depth_mem #(
    .DW    (DEPTH_BITS),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tdr_interp #(
    .ZW (DEPTH_BITS)
  ) u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ip_start),
    .z0    (DEPTH_BITS'(in_r.az)),
    .z1    (DEPTH_BITS'(in_r.bz)),
    .z2    (DEPTH_BITS'(in_r.cz)),
    .u     (u_r[WU_W-1:0]),
    .v     (v_r[WU_W-1:0]),
    .w     (w_r[WU_W-1:0]),
    .den   (den_r[WU_W-1:0]),
    .done  (ip_done),
    .q     (ip_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // A new result only comes out of the finishing state.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared outside the finishing state");

  // The store is written only by the clearing sweep or a depth update.
  a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_PIX_INTERP))
    else $error("depth store written in an unexpected state");

  // The interpolation unit finishes only while the walk waits on it.
  a_ip_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    ip_done |-> state_r == ST_PIX_INTERP)
    else $error("interpolation result arrived while not waiting");

  // The pixel walk only runs on a triangle of positive area.
  a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PIX_DOT |-> den_r > 0)
    else $error("pixel walk on a degenerate triangle");
`endif

endmodule

`default_nettype wire

// ----- test/triangle_depth_rasterizer_check.sv -----
// Scoreboard for the triangle depth rasterizer: watches the input, result and register ports,
// keeps its own copy of the depth store, and compares every result item with its prediction.
// Depends on tdr_pkg.
`timescale 1ns / 1ps

module triangle_depth_rasterizer_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tdr_pkg::tdr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tdr_pkg::tdr_out_t out_data,
  input  logic              cfg_we,
  input  logic [tdr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tdr_pkg::SCR_W-1:0]  cfg_wdata,
  output int                errors,
  output int                pending
);
  import tdr_pkg::*;

  localparam int SW = 512;
  localparam int SH = 512;

  logic [ZIN_W-1:0] zbuf [0:SW*SH-1];
  logic [SCR_W-1:0] width_reg, height_reg;
  tdr_out_t         want_q [$];

  // Active screen size, saturated to the store size.
  function automatic longint act_w();
    return (width_reg > SW) ? SW : longint'(width_reg);
  endfunction

  function automatic longint act_h();
    return (height_reg > SH) ? SH : longint'(height_reg);
  endfunction

  // Rasterizes one triangle into the local store and returns the pixels updated.
  function automatic int raster(tdr_in_t it);
    longint x0, y0, x1, y1, x2, y2, e0x, e0y, e1x, e1y;
    longint d00, d01, d11, den, mnx, mxx, mny, mxy, r, c;
    longint d20, d21, v, w, u;
    logic [79:0] acc;
    logic [79:0] quo;
    int cnt;
    x0 = it.ax; y0 = it.ay; x1 = it.bx; y1 = it.by_row; x2 = it.cx; y2 = it.cy;
    e0x = x1 - x0; e0y = y1 - y0; e1x = x2 - x0; e1y = y2 - y0;
    d00 = e0x * e0x + e0y * e0y;
    d01 = e0x * e1x + e0y * e1y;
    d11 = e1x * e1x + e1y * e1y;
    den = d00 * d11 - d01 * d01;
    cnt = 0;
    if (den <= 0) return 0;
    mnx = x0; mxx = x0; mny = y0; mxy = y0;
    if (x1 < mnx) mnx = x1;
    if (x2 < mnx) mnx = x2;
    if (x1 > mxx) mxx = x1;
    if (x2 > mxx) mxx = x2;
    if (y1 < mny) mny = y1;
    if (y2 < mny) mny = y2;
    if (y1 > mxy) mxy = y1;
    if (y2 > mxy) mxy = y2;
    if (mnx < 0) mnx = 0;
    if (mny < 0) mny = 0;
    if (mxx > act_w()) mxx = act_w();
    if (mxy > act_h()) mxy = act_h();
    for (r = mny; r < mxy; r++) begin
      for (c = mnx; c < mxx; c++) begin
        d20 = (c - x0) * e0x + (r - y0) * e0y;
        d21 = (c - x0) * e1x + (r - y0) * e1y;
        v = d11 * d20 - d01 * d21;
        w = d00 * d21 - d01 * d20;
        u = den - v - w;
        if (u >= 0 && v >= 0 && w >= 0) begin
          acc = 80'(it.az) * 80'(u) + 80'(it.bz) * 80'(v) + 80'(it.cz) * 80'(w);
          quo = acc / 80'(den);
          if (quo[ZIN_W-1:0] > zbuf[r * SW + c]) begin
            zbuf[r * SW + c] = quo[ZIN_W-1:0];
            cnt++;
          end
        end
      end
    end
    return cnt;
  endfunction

  // Works out the result item that one command causes.
  function automatic tdr_out_t predict(tdr_in_t it);
    tdr_out_t res;
    longint x, y;
    res = '0;
    case (it.func)
      FUNC_CLEAR: begin
        for (int i = 0; i < SW * SH; i++) zbuf[i] = '0;
      end
      FUNC_TRI: res.pixels_written = CNT_W'(raster(it));
      FUNC_READ: begin
        x = it.ax;
        y = it.ay;
        if (x < 0 || y < 0 || x >= act_w() || y >= act_h()) res.out_of_screen = 1'b1;
        else res.depth_out = zbuf[y * SW + x];
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    tdr_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SW * SH; i++) zbuf[i] = '0;
      width_reg  <= SCR_RESET;
      height_reg <= SCR_RESET;
      want_q.delete();
      errors <= 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_addr == REG_SCREEN_WIDTH) width_reg <= cfg_wdata;
        else if (cfg_addr == REG_SCREEN_HEIGHT) height_reg <= cfg_wdata;
      end
      // Accepted command item.
      if (in_valid && !in_stall) want_q.push_back(predict(in_data));
      // Accepted result item.
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item: %p", out_data);
          errors <= errors + 1;
        end else begin
          want = want_q.pop_front();
          if (want.depth_out != out_data.depth_out ||
              want.pixels_written != out_data.pixels_written ||
              want.out_of_screen != out_data.out_of_screen) begin
            if (errors < 10)
              $display("mismatch: expected depth %0d pixels %0d oos %0d, got %0d %0d %0d",
                       want.depth_out, want.pixels_written, want.out_of_screen,
                       out_data.depth_out, out_data.pixels_written, out_data.out_of_screen);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/triangle_depth_rasterizer_test.sv -----
// Testbench top for the triangle depth rasterizer: clock, reset, command stimulus, result
// stalls and verdict. Depends on tdr_pkg, triangle_depth_rasterizer and the scoreboard.
`timescale 1ns / 1ps

module triangle_depth_rasterizer_test;
  import tdr_pkg::*;

  localparam int WATCH_LIMIT = 1200000;
  localparam func_t FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tdr_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tdr_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [SCR_W-1:0] cfg_wdata = '0;
  int errors, pending;
  int sent = 0;
  bit calm = 0;
  int cur_w = 420, cur_h = 420;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  triangle_depth_rasterizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  triangle_depth_rasterizer_check chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // Result side: random stall bursts, and one long hold-off to back the block up.
  int stall_left = 0;
  int squeeze_left = 0;
  bit squeezed = 0;
  always @(posedge clk) begin
    if (!squeezed && sent >= 100) begin
      squeezed <= 1;
      squeeze_left <= 400;
      out_stall <= 1'b1;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one command item, with an optional gap before it, and waits until it is taken.
  task automatic send(tdr_in_t it);
    bit taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_screen(int w, int h);
    drain();
    cfg_we <= 1'b1; cfg_addr <= REG_SCREEN_WIDTH; cfg_wdata <= SCR_W'(w);
    @(posedge clk);
    cfg_addr <= REG_SCREEN_HEIGHT; cfg_wdata <= SCR_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_w = w; cur_h = h;
  endtask

  function automatic tdr_in_t tri3(int x0, int y0, int z0, int x1, int y1, int z1,
                                   int x2, int y2, int z2);
    tdr_in_t it;
    it.func = FUNC_TRI;
    it.ax = CRD_W'(x0); it.ay = CRD_W'(y0); it.az = ZIN_W'(z0);
    it.bx = CRD_W'(x1); it.by_row = CRD_W'(y1); it.bz = ZIN_W'(z1);
    it.cx = CRD_W'(x2); it.cy = CRD_W'(y2); it.cz = ZIN_W'(z2);
    return it;
  endfunction

  function automatic tdr_in_t rd(int x, int y);
    tdr_in_t it;
    it = '0;
    it.func = FUNC_READ;
    it.ax = CRD_W'(x); it.ay = CRD_W'(y);
    return it;
  endfunction

  // Random depth: mostly full range, sometimes tiny or saturated.
  function automatic int rnd_z();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 24'hffffff;
      default: return $urandom_range(0, 24'hffffff);
    endcase
  endfunction

  int last_x = 0, last_y = 0;

  // Random command item: small triangles mostly near the screen, reads mostly near recent ones, and some unused codes.
  function automatic tdr_in_t rnd_item();
    tdr_in_t it;
    int bx, by, k;
    int span_w, span_h;
    k = $urandom_range(0, 99);
    span_w = (cur_w > 512) ? 512 : ((cur_w < 1) ? 1 : cur_w);
    span_h = (cur_h > 512) ? 512 : ((cur_h < 1) ? 1 : cur_h);
    if (k < 48) begin
      if ($urandom_range(0, 9) < 7) begin
        bx = $urandom_range(0, span_w + 2) - 3;
        by = $urandom_range(0, span_h + 2) - 3;
      end else begin
        bx = $urandom_range(0, 4095) - 2048;
        by = $urandom_range(0, 4095) - 2048;
      end
      last_x = bx + 2; last_y = by + 2;
      it = tri3(bx + $urandom_range(0, 5), by + $urandom_range(0, 5), rnd_z(),
                bx + $urandom_range(0, 5), by + $urandom_range(0, 5), rnd_z(),
                bx + $urandom_range(0, 5), by + $urandom_range(0, 5), rnd_z());
    end else if (k < 95) begin
      if ($urandom_range(0, 9) < 7)
        it = rd(last_x + $urandom_range(0, 6) - 3, last_y + $urandom_range(0, 6) - 3);
      else
        it = rd($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
      it.az = ZIN_W'($urandom); it.bx = CRD_W'($urandom); it.cz = ZIN_W'($urandom);
    end else begin
      // Unused command code with random payload.
      it = tdr_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  initial begin
    int ws [6];
    int hs [6];
    tdr_in_t it;
    ws = '{512, 1023, 1, 0, 300, 420};
    hs = '{512, 1023, 1, 5, 97, 420};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset screen size.
    it = '0;
    it.func = FUNC_CLEAR;
    send(it);
    send(rd(0, 0));
    send(tri3(2, 2, 1000, 12, 2, 2000, 2, 12, 3000));
    send(rd(3, 3));
    send(tri3(2, 2, 1000, 12, 2, 2000, 2, 12, 3000));
    send(tri3(12, 2, 24'hffffff, 2, 2, 24'hffffff, 2, 12, 24'hffffff));
    send(rd(2, 2));
    send(tri3(1, 1, 5, 4, 4, 5, 7, 7, 5));
    send(tri3(20, 20, 0, 26, 20, 0, 20, 26, 0));
    send(rd(21, 21));
    send(tri3(-2048, 0, 777, 3, 0, 888, 0, 3, 999));
    send(tri3(2047, 2047, 1, 2040, 2047, 2, 2047, 2040, 3));
    send(tri3(-2048, -2048, 9, -2040, -2048, 9, -2048, -2040, 9));
    send(tri3(414, 414, 50000, 425, 414, 60000, 414, 425, 70000));
    send(rd(419, 419));
    send(rd(420, 0));
    send(rd(0, 420));
    send(rd(-1, 5));
    send(rd(2047, -2048));
    it = '1;
    it.func = FUNC_UNUSED;
    send(it);
    send(rd(1, 0));

    // Random phases over several screen sizes; the last one runs its later items without idling.
    for (int p = 0; p < 6; p++) begin
      set_screen(ws[p], hs[p]);
      for (int n = 0; n < 93; n++) begin
        if (p == 5 && n >= 33) calm = 1;
        send(rnd_item());
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- triangle_depth_rasterizer.f -----
sv/tdr_pkg.sv
sv/tdr_depth_mem.sv
sv/tdr_interp.sv
sv/triangle_depth_rasterizer.sv
test/triangle_depth_rasterizer_check.sv
test/triangle_depth_rasterizer_test.sv
